/* src/afp_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the ASCII triple-integer frame parser.
// Used by the front classifier, the token queue, the back parser and the top level.
package afp_pkg;

	localparam int MAX_FRAME_BYTES = 16;
	localparam int LEN_W = $clog2(MAX_FRAME_BYTES + 1);

	localparam int VALUE_W = 32;
	localparam int COUNT_W = 2;
	localparam int NUM_FIELDS = 3;
	localparam int RESULT_W = NUM_FIELDS * VALUE_W + COUNT_W;
	localparam int RESULT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] CHAR_START = 8'h61;
	localparam logic [7:0] CHAR_END = 8'h65;
	localparam logic [7:0] CHAR_PLUS = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB = 8'h09;
	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	localparam logic [VALUE_W-1:0] MAG_CAP = 32'h8000_0000;
	localparam logic [VALUE_W-1:0] POS_MAX = 32'h7FFF_FFFF;

	typedef enum logic [2:0] {
		TK_WS,
		TK_PLUS,
		TK_MINUS,
		TK_DIGIT,
		TK_START,
		TK_END,
		TK_OTHER
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t kind;
		logic [3:0] digit;
	} token_t;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_SKIP,
		PH_SIGN,
		PH_DIGITS,
		PH_STOP
	} phase_t;

endpackage

/* src/afp_front.sv */
`timescale 1ns / 1ps
// Front stage: accepts received bytes and classifies each into a token.
// Depends on afp_pkg for the token type and character codes.
module afp_front import afp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       tok_valid,
	input  logic       tok_ready,
	output token_t     tok
);

	token_t cls;
	logic   valid_s1;
	token_t tok_s1;

	always_comb begin
		cls.digit = 4'(in_byte - CHAR_ZERO);
		priority if (in_byte == CHAR_SPACE || (in_byte >= CHAR_TAB && in_byte <= CHAR_CR)) begin
			cls.kind = TK_WS;
		end else if (in_byte == CHAR_PLUS) begin
			cls.kind = TK_PLUS;
		end else if (in_byte == CHAR_MINUS) begin
			cls.kind = TK_MINUS;
		end else if (in_byte >= CHAR_ZERO && in_byte <= CHAR_NINE) begin
			cls.kind = TK_DIGIT;
		end else if (in_byte == CHAR_START) begin
			cls.kind = TK_START;
		end else if (in_byte == CHAR_END) begin
			cls.kind = TK_END;
		end else begin
			cls.kind = TK_OTHER;
		end
	end

	assign in_ready = !valid_s1 || tok_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			tok_s1 <= cls;
		end
	end

	assign tok_valid = valid_s1;
	assign tok = tok_s1;

endmodule

/* src/afp_queue.sv */
`timescale 1ns / 1ps
// Short token queue between the front classifier and the back parser.
// Depends on afp_pkg for the token type and queue depth.
module afp_queue import afp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr_valid,
	output logic   wr_ready,
	input  token_t wr_tok,
	output logic   rd_valid,
	input  logic   rd_ready,
	output token_t rd_tok
);

	token_t mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic push;
	logic pop;

	assign wr_ready = count_q != (QPTR_W+1)'(QUEUE_DEPTH);
	assign rd_valid = count_q != '0;
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;
	assign rd_tok = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* src/afp_back.sv */
`timescale 1ns / 1ps
// Back stage: runs the frame parser on classified tokens and registers each result.
// Depends on afp_pkg for the token, phase types and field constants.
module afp_back import afp_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      tok_valid,
	output logic                      tok_ready,
	input  token_t                    tok,
	output logic                      res_valid,
	input  logic                      res_ready,
	output logic [RESULT_TDATA_W-1:0] res_data
);

	phase_t phase_q;
	phase_t phase_d;
	logic [1:0]         field_q;
	logic [1:0]         field_d;
	logic [VALUE_W-1:0] acc_q;
	logic [VALUE_W-1:0] acc_d;
	logic               neg_q;
	logic               neg_d;
	logic [LEN_W-1:0]   len_q;
	logic [LEN_W-1:0]   len_d;
	logic [VALUE_W-1:0] staged_q [NUM_FIELDS];
	logic [VALUE_W-1:0] held_q [NUM_FIELDS];
	logic [VALUE_W-1:0] held_d [NUM_FIELDS];
	logic               stage_we;

	logic               take;
	logic               is_digit;
	logic               is_sign;
	logic               overlong;
	logic [VALUE_W-1:0] fin_val;
	logic [VALUE_W+3:0] prod;
	logic [VALUE_W-1:0] acc_mac;
	logic [1:0]         n_fields;
	logic               emit;
	logic               out_valid_q;
	logic [RESULT_TDATA_W-1:0] out_data_q;

	assign tok_ready = !out_valid_q || res_ready;
	assign take = tok_valid && tok_ready;
	assign is_digit = tok.kind == TK_DIGIT;
	assign is_sign = tok.kind == TK_PLUS || tok.kind == TK_MINUS;
	assign overlong = (len_q + 1'b1) == LEN_W'(MAX_FRAME_BYTES);

	always_comb begin
		if (neg_q) begin
			fin_val = 32'(0) - acc_q;
		end else if (acc_q[VALUE_W-1]) begin
			fin_val = POS_MAX;
		end else begin
			fin_val = acc_q;
		end
	end

	assign prod = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + (VALUE_W+4)'(tok.digit);
	assign acc_mac = (prod > (VALUE_W+4)'(MAG_CAP)) ? MAG_CAP : prod[VALUE_W-1:0];

	always_comb begin
		phase_d = phase_q;
		if (take) begin
			priority if (phase_q == PH_HUNT) begin
				if (tok.kind == TK_START) begin
					phase_d = PH_SKIP;
				end
			end else if (tok.kind == TK_END || overlong) begin
				phase_d = PH_HUNT;
			end else begin
				unique case (phase_q)
					PH_SIGN: begin
						phase_d = is_digit ? PH_DIGITS : PH_STOP;
					end
					PH_SKIP, PH_DIGITS: begin
						if (phase_q == PH_DIGITS && is_digit) begin
							phase_d = PH_DIGITS;
						end else if (phase_q == PH_DIGITS && field_q == 2'd2) begin
							phase_d = PH_STOP;
						end else if (tok.kind == TK_WS) begin
							phase_d = PH_SKIP;
						end else if (is_sign) begin
							phase_d = PH_SIGN;
						end else if (is_digit) begin
							phase_d = PH_DIGITS;
						end else begin
							phase_d = PH_STOP;
						end
					end
					default: begin
						phase_d = PH_STOP;
					end
				endcase
			end
		end
	end

	always_comb begin
		field_d = field_q;
		acc_d = acc_q;
		neg_d = neg_q;
		len_d = len_q;
		stage_we = 1'b0;
		emit = 1'b0;
		n_fields = field_q;
		for (int i = 0; i < NUM_FIELDS; i++) begin
			held_d[i] = held_q[i];
		end
		if (take) begin
			priority if (phase_q == PH_HUNT) begin
				if (tok.kind == TK_START) begin
					field_d = '0;
					acc_d = '0;
					neg_d = 1'b0;
					len_d = LEN_W'(1);
				end
			end else if (tok.kind == TK_END) begin
				n_fields = field_q + 2'(phase_q == PH_DIGITS);
				for (int i = 0; i < NUM_FIELDS; i++) begin
					if (2'(i) < n_fields) begin
						held_d[i] = (phase_q == PH_DIGITS && 2'(i) == field_q) ?
							fin_val : staged_q[i];
					end
				end
				emit = 1'b1;
				field_d = '0;
				acc_d = '0;
				neg_d = 1'b0;
				len_d = '0;
			end else if (overlong) begin
				field_d = '0;
				acc_d = '0;
				neg_d = 1'b0;
				len_d = '0;
			end else begin
				len_d = len_q + 1'b1;
				if (phase_q == PH_DIGITS && is_digit) begin
					acc_d = acc_mac;
				end else if (phase_q == PH_SIGN) begin
					acc_d = {28'b0, tok.digit};
				end else if (phase_q == PH_SKIP || phase_q == PH_DIGITS) begin
					if (phase_q == PH_DIGITS) begin
						stage_we = 1'b1;
						field_d = field_q + 1'b1;
					end
					if (is_sign) begin
						neg_d = tok.kind == TK_MINUS;
						acc_d = '0;
					end else if (is_digit) begin
						neg_d = 1'b0;
						acc_d = {28'b0, tok.digit};
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_FIELDS; i++) begin
			if (stage_we && field_q == 2'(i)) begin
				staged_q[i] <= fin_val;
			end
		end
		if (emit) begin
			out_data_q <= RESULT_TDATA_W'({n_fields, held_d[2], held_d[1], held_d[0]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			field_q <= '0;
			acc_q <= '0;
			neg_q <= 1'b0;
			len_q <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_FIELDS; i++) begin
				held_q[i] <= '0;
			end
		end else begin
			phase_q <= phase_d;
			field_q <= field_d;
			acc_q <= acc_d;
			neg_q <= neg_d;
			len_q <= len_d;
			for (int i = 0; i < NUM_FIELDS; i++) begin
				held_q[i] <= held_d[i];
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = out_valid_q;
	assign res_data = out_data_q;

endmodule

/* src/ascii_triple_int_frame_parser.sv */
`timescale 1ns / 1ps
// Top level of the ASCII triple-integer frame parser.
// Instantiates afp_front, afp_queue and afp_back; uses afp_pkg.

// The parser takes one received byte per item, finds frames of the form "a%d %d %de" and
// emits one item per frame on the end marker with three values and the count of fields that
// parsed; values that did not parse keep their earlier contents. A byte passes through the
// classifier register and a two-entry token queue before the parser consumes it, so with the
// receiver ready the parser registers a result once its end marker has passed both.
// Every stage handles one byte per cycle, so bytes can follow back to back; the input stalls
// only while a result waits unaccepted in the output register and the queue and classifier
// register have filled behind it, which takes three more bytes. Frames that grow to the
// maximum length without an end marker are dropped without output.
module ascii_triple_int_frame_parser import afp_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [7:0]                s_axis_tdata,  // rx_byte
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// first_value, second_value, third_value, fields_parsed, zero pad
	output logic [RESULT_TDATA_W-1:0] m_axis_tdata
);

	logic   f_valid;
	logic   f_ready;
	token_t f_tok;
	logic   q_valid;
	logic   q_ready;
	token_t q_tok;

	afp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.tok_valid (f_valid),
		.tok_ready (f_ready),
		.tok       (f_tok)
	);

	afp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_tok   (f_tok),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_tok   (q_tok)
	);

	afp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (q_valid),
		.tok_ready (q_ready),
		.tok       (q_tok),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res_data  (m_axis_tdata)
	);

endmodule
